### design/load_cell_serial_reader_top_assert.svh
// ----------------------------------------------------------------------------
// Load-cell serial reader assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_SERIAL_READER_TOP_ASSERT_SVH
`define LOAD_CELL_SERIAL_READER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LCSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LCSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/lcsr_pkg.sv
// ----------------------------------------------------------------------------
// Load-cell serial reader package
// Shared constants, codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcsr_pkg;

	localparam int DATA_BITS_DEF = 24;
	localparam int MAX_AVG_DEF   = 16;
	localparam int SCALE_W       = 24;
	localparam int RES_W         = 25;
	localparam int GAIN_W        = 2;
	localparam int AVG_W         = 5;
	localparam int CFG_IDX_W     = 2;

	localparam logic [1:0] FUNC_MEAS = 2'd1;
	localparam logic [1:0] FUNC_TARE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AVG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

	typedef struct packed {
		logic out_load;   // load a plain per-tick result
		logic sck;
		logic busy;
		logic clr_all;    // start of a sequence
		logic clr_shift;  // start of a conversion word
		logic shift_in;
		logic finish;     // accumulate the finished word
		logic avg_go;
		logic scl_go;
		logic tare_done;
		logic meas_done;
	} lcsr_cmd_t;

	typedef struct packed {
		logic              out_free;
		logic              last_sample;
		logic              div_done;
		logic [GAIN_W-1:0] pulses;
	} lcsr_sts_t;

endpackage

### design/lcsr_div.sv
// ----------------------------------------------------------------------------
// Load-cell serial reader divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcsr_div #(
	parameter int DVD_W = 29,
	parameter int DVS_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dvd,
	input  logic [DVS_W-1:0] dvs,
	output logic             done,
	output logic [DVD_W-1:0] quo
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DVS_W:0] rem_sh;
	logic [DVS_W:0] rem_nx;
	logic           ge;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd;
			dvs_q <= dvs;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_nx[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### design/lcsr_dp.sv
// ----------------------------------------------------------------------------
// Load-cell serial reader datapath
// Configuration registers, shift word, accumulator, offset, divider and
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcsr_dp #(
	parameter int DATA_BITS = lcsr_pkg::DATA_BITS_DEF,
	parameter int MAX_AVG   = lcsr_pkg::MAX_AVG_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lcsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lcsr_pkg::SCALE_W-1:0]        cfg_data,
	input  logic                                dout_level,
	input  lcsr_pkg::lcsr_cmd_t                 cmd,
	output lcsr_pkg::lcsr_sts_t                 sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                sck_level,
	output logic                                busy_res,
	output logic                                result_valid,
	output logic                                result_kind,
	output logic signed [lcsr_pkg::RES_W-1:0]   result_value
);

	localparam int CNT_W  = $clog2(MAX_AVG + 1);
	localparam int SUM_W  = DATA_BITS + CNT_W;
	localparam int DIFF_W = DATA_BITS + 1;
	localparam int RES_W  = lcsr_pkg::RES_W;
	localparam int SCL_W  = lcsr_pkg::SCALE_W;

	logic [lcsr_pkg::GAIN_W-1:0] gain_q;
	logic [lcsr_pkg::AVG_W-1:0]  avg_q;
	logic [SCL_W-1:0]            scale_q;

	logic [DATA_BITS-1:0] shift_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DATA_BITS-1:0] off_q;
	logic                 neg_q;

	logic                 out_valid_q;
	logic                 sck_q;
	logic                 busy_q;
	logic                 rv_q;
	logic                 kind_q;
	logic [RES_W-1:0]     val_q;

	logic [CNT_W-1:0]     n_eff;
	logic [SCL_W-1:0]     scale_eff;
	logic [DATA_BITS-1:0] word;
	logic [SUM_W-1:0]     dvd;
	logic [SCL_W-1:0]     dvs;
	logic                 div_done;
	logic [SUM_W-1:0]     quo;
	logic [DATA_BITS-1:0] avg;
	logic [DIFF_W-1:0]    diff;
	logic [DIFF_W-1:0]    mag;
	logic [RES_W-1:0]     q_ext;
	logic                 load_any;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= lcsr_pkg::GAIN_W'(1);
			avg_q   <= lcsr_pkg::AVG_W'(5);
			scale_q <= SCL_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcsr_pkg::CFG_GAIN:  gain_q  <= cfg_data[lcsr_pkg::GAIN_W-1:0];
				lcsr_pkg::CFG_AVG:   avg_q   <= cfg_data[lcsr_pkg::AVG_W-1:0];
				lcsr_pkg::CFG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (avg_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(avg_q) > MAX_AVG) begin
			n_eff = CNT_W'(MAX_AVG);
		end else begin
			n_eff = CNT_W'(avg_q);
		end
	end

	assign scale_eff = (scale_q == '0) ? SCL_W'(1) : scale_q;
	assign word      = {~shift_q[DATA_BITS-1], shift_q[DATA_BITS-2:0]};

	assign avg  = quo[DATA_BITS-1:0];
	assign diff = {1'b0, avg} - {1'b0, off_q};
	assign mag  = diff[DIFF_W-1] ? (-diff) : diff;

	assign dvd = cmd.scl_go ? SUM_W'(mag) : sum_q;
	assign dvs = cmd.scl_go ? scale_eff : SCL_W'(n_eff);

	lcsr_div #(
		.DVD_W(SUM_W),
		.DVS_W(SCL_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.avg_go | cmd.scl_go),
		.dvd   (dvd),
		.dvs   (dvs),
		.done  (div_done),
		.quo   (quo)
	);

	assign q_ext = RES_W'(quo[DATA_BITS:0]);

	// Conversion state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			off_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			if (cmd.clr_all) begin
				shift_q <= '0;
				sum_q   <= '0;
				cnt_q   <= '0;
			end
			if (cmd.clr_shift) begin
				shift_q <= '0;
			end
			if (cmd.shift_in) begin
				shift_q <= {shift_q[DATA_BITS-2:0], dout_level};
			end
			if (cmd.finish) begin
				sum_q <= sum_q + SUM_W'(word);
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.scl_go) begin
				neg_q <= diff[DIFF_W-1];
			end
			if (cmd.tare_done) begin
				off_q <= avg;
			end
		end
	end

	// Output register.
	assign load_any = cmd.out_load | cmd.tare_done | cmd.meas_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_any) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sck_q  <= cmd.sck;
			busy_q <= cmd.busy;
			rv_q   <= 1'b0;
			kind_q <= 1'b0;
			val_q  <= '0;
		end else if (cmd.tare_done) begin
			sck_q  <= 1'b0;
			busy_q <= 1'b0;
			rv_q   <= 1'b1;
			kind_q <= 1'b1;
			val_q  <= RES_W'(avg);
		end else if (cmd.meas_done) begin
			sck_q  <= 1'b0;
			busy_q <= 1'b0;
			rv_q   <= 1'b1;
			kind_q <= 1'b0;
			val_q  <= neg_q ? (-q_ext) : q_ext;
		end
	end

	assign sts.out_free    = ~out_valid_q | out_ready;
	assign sts.last_sample = (({1'b0, cnt_q} + (CNT_W+1)'(1)) >= {1'b0, n_eff});
	assign sts.div_done    = div_done;
	assign sts.pulses      = (gain_q == '0) ? lcsr_pkg::GAIN_W'(1) : gain_q;

	assign out_valid    = out_valid_q;
	assign sck_level    = sck_q;
	assign busy_res     = busy_q;
	assign result_valid = rv_q;
	assign result_kind  = kind_q;
	assign result_value = val_q;

	`include "load_cell_serial_reader_top_assert.svh"

	`LCSR_ASSERT_IMP(a_dp_load_free, load_any, !out_valid_q || out_ready, "output register overwritten")
	`LCSR_ASSERT_NEXT(a_dp_out_hold, out_valid_q && !out_ready, out_valid_q, "output dropped")
	`LCSR_ASSERT_IMP(a_dp_plain_zero, out_valid_q && !rv_q, !kind_q && val_q == '0, "plain tick data")

endmodule

### design/lcsr_ctrl.sv
// ----------------------------------------------------------------------------
// Load-cell serial reader controller
// Serial clock sequencer and the handshake/divide control state machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcsr_ctrl #(
	parameter int DATA_BITS = lcsr_pkg::DATA_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  logic                dout_level,
	input  lcsr_pkg::lcsr_sts_t sts,
	output lcsr_pkg::lcsr_cmd_t cmd
);

	localparam int BIT_W = $clog2(DATA_BITS + 1);

	localparam logic [2:0] ST_RUN      = 3'd0;
	localparam logic [2:0] ST_AVG_GO   = 3'd1;
	localparam logic [2:0] ST_AVG_WAIT = 3'd2;
	localparam logic [2:0] ST_SCL_GO   = 3'd3;
	localparam logic [2:0] ST_SCL_WAIT = 3'd4;

	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_WAIT       = 3'd1;
	localparam logic [2:0] PH_BIT_LOW    = 3'd2;
	localparam logic [2:0] PH_BIT_HIGH   = 3'd3;
	localparam logic [2:0] PH_EXTRA_LOW  = 3'd4;
	localparam logic [2:0] PH_EXTRA_HIGH = 3'd5;

	logic [2:0]       st_q, st_d;
	logic [2:0]       ph_q, ph_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic             tare_q, tare_d;
	logic [BIT_W:0]   bit_inc;
	logic             accept;

	assign in_ready = (st_q == ST_RUN) & sts.out_free;
	assign accept   = in_valid & in_ready;
	assign bit_inc  = {1'b0, bit_q} + (BIT_W+1)'(1);

	always_comb begin
		cmd    = '0;
		st_d   = st_q;
		ph_d   = ph_q;
		bit_d  = bit_q;
		tare_d = tare_q;
		unique case (st_q)
			ST_RUN: begin
				if (accept) begin
					cmd.out_load = 1'b1;
					cmd.sck      = 1'b0;
					cmd.busy     = 1'b1;
					unique case (ph_q)
						PH_IDLE: begin
							cmd.busy = 1'b0;
							if (func == lcsr_pkg::FUNC_MEAS || func == lcsr_pkg::FUNC_TARE) begin
								tare_d      = (func == lcsr_pkg::FUNC_TARE);
								cmd.clr_all = 1'b1;
								cmd.busy    = 1'b1;
								bit_d       = '0;
								ph_d        = PH_WAIT;
							end
						end
						PH_WAIT: begin
							if (!dout_level) begin
								cmd.clr_shift = 1'b1;
								cmd.sck       = 1'b1;
								bit_d         = '0;
								ph_d          = PH_BIT_HIGH;
							end
						end
						PH_BIT_LOW: begin
							cmd.sck = 1'b1;
							ph_d    = PH_BIT_HIGH;
						end
						PH_BIT_HIGH: begin
							cmd.shift_in = 1'b1;
							if (bit_inc >= (BIT_W+1)'(DATA_BITS)) begin
								bit_d = '0;
								ph_d  = PH_EXTRA_LOW;
							end else begin
								bit_d = bit_inc[BIT_W-1:0];
								ph_d  = PH_BIT_LOW;
							end
						end
						PH_EXTRA_LOW: begin
							cmd.sck = 1'b1;
							ph_d    = PH_EXTRA_HIGH;
						end
						PH_EXTRA_HIGH: begin
							if (bit_inc >= (BIT_W+1)'(sts.pulses)) begin
								bit_d      = '0;
								cmd.finish = 1'b1;
								if (sts.last_sample) begin
									// The result comes from the divider instead.
									cmd.out_load = 1'b0;
									ph_d         = PH_IDLE;
									st_d         = ST_AVG_GO;
								end else begin
									ph_d = PH_WAIT;
								end
							end else begin
								bit_d = bit_inc[BIT_W-1:0];
								ph_d  = PH_EXTRA_LOW;
							end
						end
						default: begin
							cmd.busy = 1'b0;
							ph_d     = PH_IDLE;
						end
					endcase
				end
			end
			ST_AVG_GO: begin
				cmd.avg_go = 1'b1;
				st_d       = ST_AVG_WAIT;
			end
			ST_AVG_WAIT: begin
				if (sts.div_done) begin
					if (tare_q) begin
						cmd.tare_done = 1'b1;
						st_d          = ST_RUN;
					end else begin
						st_d = ST_SCL_GO;
					end
				end
			end
			ST_SCL_GO: begin
				cmd.scl_go = 1'b1;
				st_d       = ST_SCL_WAIT;
			end
			ST_SCL_WAIT: begin
				if (sts.div_done) begin
					cmd.meas_done = 1'b1;
					st_d          = ST_RUN;
				end
			end
			default: begin
				st_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_RUN;
			ph_q   <= PH_IDLE;
			bit_q  <= '0;
			tare_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			ph_q   <= ph_d;
			bit_q  <= bit_d;
			tare_q <= tare_d;
		end
	end

	`include "load_cell_serial_reader_top_assert.svh"

	`LCSR_ASSERT_IMP(a_ctrl_no_accept_div, st_q != ST_RUN, !in_ready, "input taken during divide")
	`LCSR_ASSERT_IMP(a_ctrl_done_in_wait, sts.div_done, st_q == ST_AVG_WAIT || st_q == ST_SCL_WAIT, "divider done outside a wait state")
	`LCSR_ASSERT_NEXT(a_ctrl_last_to_div, cmd.finish && sts.last_sample, st_q == ST_AVG_GO && ph_q == PH_IDLE, "last word did not start the average")

endmodule

### design/load_cell_serial_reader_top.sv
// ----------------------------------------------------------------------------
// Load-cell serial reader, top level
// Serial readout of a 24-bit load-cell converter with averaging, tare and
// scaling.
// ----------------------------------------------------------------------------
// Each input transaction is one tick, one half period of the converter's
// serial clock, and produces exactly one output transaction carrying the
// clock level to drive next, a busy flag and, on the tick that ends a
// measurement or tare, the result. An ordinary tick is written to the
// output register when it is accepted. A new tick is accepted only when
// the output register is empty or its result is taken in that same cycle.
// The tick that completes a sequence runs the shared one-bit-per-cycle
// restoring divider: a tare takes one pass (sum / sample count) and a
// measurement two passes (average, then offset difference / scale
// divisor). Each pass produces a quotient of DATA_BITS + clog2(MAX_AVG+1)
// bits, and no input is accepted while the divider runs. Configuration
// writes are always accepted (cfg_ready is tied high) and take effect at
// once; index 0 is gain_pulses, 1 avg_count, 2 scale_divisor, and index 3
// is ignored. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module load_cell_serial_reader_top #(
	parameter int DATA_BITS = lcsr_pkg::DATA_BITS_DEF,
	parameter int MAX_AVG   = lcsr_pkg::MAX_AVG_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Tick input.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [0] dout_level, [7:1] zero
	input  logic [1:0]                     s_tuser,   // [1:0] func
	// Result output.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // [0] sck_level, [1] busy_res,
	                                                  // [2] result_valid,
	                                                  // [27:3] result_value, [31:28] zero
	output logic [0:0]                     m_tuser,   // [0] result_kind
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lcsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcsr_pkg::SCALE_W-1:0]   cfg_data
);

	lcsr_pkg::lcsr_cmd_t cmd;
	lcsr_pkg::lcsr_sts_t sts;

	logic                                sck_level;
	logic                                busy_res;
	logic                                result_valid;
	logic                                result_kind;
	logic signed [lcsr_pkg::RES_W-1:0]   result_value;

	// Registers never stall a write transaction.
	assign cfg_ready = 1'b1;

	lcsr_ctrl #(
		.DATA_BITS(DATA_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.func      (s_tuser),
		.dout_level(s_tdata[0]),
		.sts       (sts),
		.cmd       (cmd)
	);

	lcsr_dp #(
		.DATA_BITS(DATA_BITS),
		.MAX_AVG  (MAX_AVG)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.dout_level  (s_tdata[0]),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.sck_level   (sck_level),
		.busy_res    (busy_res),
		.result_valid(result_valid),
		.result_kind (result_kind),
		.result_value(result_value)
	);

	// Pack the result fields, lowest field in the lowest bits.
	assign m_tdata = {4'b0000, result_value, result_valid, busy_res, sck_level};
	assign m_tuser = result_kind;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// Load-cell serial reader testbench
// Each accepted input tick goes through a cycle-free model of the readout
// sequencer and the expected output is queued. Every output transaction is
// compared field by field with the oldest queued entry. The run starts with
// a short table of hand-checked ticks. It then plays a converter that answers
// measure and tare commands with extreme and random words, under several
// register settings and varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	// Function codes that the package does not name.
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_NONE = 2'd3;   // undefined code, behaves as a tick

	localparam int          WORD_BITS  = lcsr_pkg::DATA_BITS_DEF;
	localparam logic [23:0] TOP_BIT    = 24'h800000;
	localparam int          N_PHASES   = 7;
	localparam int          HOLD_TICKS = 400;

	typedef enum logic [2:0] {
		RD_IDLE, RD_WAIT, RD_BIT_LOW, RD_BIT_HIGH, RD_EXTRA_LOW, RD_EXTRA_HIGH
	} rd_state_t;

	// One output transaction as the sequencer should produce it.
	typedef struct packed {
		logic               sck;
		logic               busy;
		logic               done;
		logic               kind;
		logic signed [24:0] value;
	} reading_t;

	typedef struct packed {
		logic [1:0] func;
		logic       dout;
		logic       known;     // use the typed-in expectation below
		reading_t   want;
	} tick_row_t;

	localparam reading_t QUIET     = '0;
	localparam reading_t BUSY_LOW  = '{busy: 1'b1, default: '0};
	localparam reading_t BUSY_HIGH = '{sck: 1'b1, busy: 1'b1, default: '0};

	// Opening ticks at reset settings: idle ticks, the undefined code, a
	// measurement start, commands while busy, the data line dropping and the
	// first clock pulses of a word.
	localparam tick_row_t OPENING_TICKS [14] = '{
		'{FUNC_TICK, 1'b0, 1'b1, QUIET},
		'{FUNC_TICK, 1'b1, 1'b1, QUIET},
		'{FUNC_NONE, 1'b0, 1'b1, QUIET},
		'{FUNC_NONE, 1'b1, 1'b1, QUIET},
		'{lcsr_pkg::FUNC_MEAS, 1'b1, 1'b1, BUSY_LOW},
		'{FUNC_TICK, 1'b1, 1'b1, BUSY_LOW},
		'{lcsr_pkg::FUNC_TARE, 1'b1, 1'b1, BUSY_LOW},
		'{lcsr_pkg::FUNC_MEAS, 1'b1, 1'b1, BUSY_LOW},
		'{FUNC_NONE, 1'b1, 1'b1, BUSY_LOW},
		'{FUNC_TICK, 1'b0, 1'b1, BUSY_HIGH},
		'{FUNC_TICK, 1'b1, 1'b1, BUSY_LOW},
		'{lcsr_pkg::FUNC_TARE, 1'b0, 1'b1, BUSY_HIGH},
		'{FUNC_TICK, 1'b0, 1'b1, BUSY_LOW},
		'{lcsr_pkg::FUNC_MEAS, 1'b1, 1'b1, BUSY_HIGH}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [7:0]                     s_tdata;   // [0] dout_level, [7:1] zero
	logic [1:0]                     s_tuser;   // [1:0] func
	logic                           m_tvalid;
	logic                           m_tready;
	logic [31:0]                    m_tdata;   // [0] sck_level, [1] busy_res,
	                                           // [2] result_valid,
	                                           // [27:3] result_value, [31:28] zero
	logic [0:0]                     m_tuser;   // [0] result_kind
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [lcsr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lcsr_pkg::SCALE_W-1:0]   cfg_data;

	// Sequencer model state and its copy of the registers.
	rd_state_t   rd_state;
	int          bit_cnt;
	logic [23:0] shift_reg;
	logic [27:0] acc_sum;
	int          acc_cnt;
	logic [23:0] zero_ofs;
	logic        tare_run;
	logic        sck_lvl;
	logic [1:0]  reg_gain;
	logic [4:0]  reg_avg;
	logic [23:0] reg_scale;

	reading_t    readings_q [$];
	int          mismatches;
	int          finished_runs;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_request;
	logic [23:0] conv_word;      // word the emulated converter is sending

	load_cell_serial_reader_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Advances the sequencer model by one tick and returns what it drives.
	task automatic advance_reader(input logic [1:0] f, input logic d, output reading_t r);
		logic [23:0] word;
		int          n;
		int          pulses;
		longint      mean;
		longint      diff;
		longint      quot;
		r = '0;
		pulses = (reg_gain == 2'd0) ? 1 : int'(reg_gain);
		case (rd_state)
			RD_IDLE: begin
				sck_lvl = 1'b0;
				if (f == lcsr_pkg::FUNC_MEAS || f == lcsr_pkg::FUNC_TARE) begin
					tare_run  = (f == lcsr_pkg::FUNC_TARE);
					acc_sum   = '0;
					acc_cnt   = 0;
					bit_cnt   = 0;
					shift_reg = '0;
					rd_state  = RD_WAIT;
				end
			end
			RD_WAIT: begin
				sck_lvl = 1'b0;
				// Converter signals a ready word by pulling its data line low.
				if (!d) begin
					bit_cnt   = 0;
					shift_reg = '0;
					sck_lvl   = 1'b1;
					rd_state  = RD_BIT_HIGH;
				end
			end
			RD_BIT_LOW: begin
				sck_lvl  = 1'b1;
				rd_state = RD_BIT_HIGH;
			end
			RD_BIT_HIGH: begin
				shift_reg = {shift_reg[22:0], d};
				sck_lvl   = 1'b0;
				bit_cnt++;
				if (bit_cnt >= WORD_BITS) begin
					bit_cnt  = 0;
					rd_state = RD_EXTRA_LOW;
				end else begin
					rd_state = RD_BIT_LOW;
				end
			end
			RD_EXTRA_LOW: begin
				sck_lvl  = 1'b1;
				rd_state = RD_EXTRA_HIGH;
			end
			RD_EXTRA_HIGH: begin
				sck_lvl = 1'b0;
				bit_cnt++;
				if (bit_cnt >= pulses) begin
					bit_cnt = 0;
					// Offset binary: flipping the sign bit maps the two's
					// complement reading onto 0 .. 2^24-1.
					word = shift_reg ^ TOP_BIT;
					if (reg_avg == 5'd0)
						n = 1;
					else if (reg_avg > lcsr_pkg::MAX_AVG_DEF)
						n = lcsr_pkg::MAX_AVG_DEF;
					else
						n = int'(reg_avg);
					acc_sum = acc_sum + {4'b0, word};
					acc_cnt++;
					if (acc_cnt < n) begin
						rd_state = RD_WAIT;
					end else begin
						mean     = longint'(acc_sum) / n;
						rd_state = RD_IDLE;
						r.done   = 1'b1;
						if (tare_run) begin
							zero_ofs = mean[23:0];
							r.kind   = 1'b1;
							r.value  = {1'b0, zero_ofs};
						end else begin
							diff    = mean - longint'(zero_ofs);
							quot    = diff / ((reg_scale == '0) ? 64'sd1 : longint'(reg_scale));
							r.value = quot[24:0];
						end
					end
				end else begin
					rd_state = RD_EXTRA_LOW;
				end
			end
			default: begin
				rd_state = RD_IDLE;
				sck_lvl  = 1'b0;
			end
		endcase
		r.sck  = sck_lvl;
		r.busy = (rd_state != RD_IDLE);
	endtask

	// Offers one tick, waits until it is accepted and queues the expectation.
	task automatic send_tick(input logic [1:0] f, input logic d, input logic known,
			input reading_t typed);
		reading_t pred;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, d};
		s_tuser  <= f;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		advance_reader(f, d, pred);
		if (pred.done)
			finished_runs++;
		readings_q.push_back(known ? typed : pred);
	endtask

	function automatic logic [23:0] pick_word();
		case ($urandom_range(5))
			0:       return 24'h000000;
			1:       return 24'hFFFFFF;
			2:       return 24'h800000;
			3:       return 24'h7FFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	// Plays the converter: commands when the sequencer is idle, a data line
	// that drops after a while, and the chosen word bit by bit. A few ticks
	// are pure noise or commands that arrive while busy.
	task automatic next_tick(output logic [1:0] f, output logic d);
		f = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : FUNC_TICK;
		d = 1'($urandom_range(1));
		if ($urandom_range(99) < 5)
			return;
		case (rd_state)
			RD_IDLE: begin
				conv_word = pick_word();
				if ($urandom_range(9) < 8)
					f = ($urandom_range(2) == 0) ? lcsr_pkg::FUNC_TARE : lcsr_pkg::FUNC_MEAS;
				else
					f = ($urandom_range(1) == 0) ? FUNC_TICK : FUNC_NONE;
			end
			RD_WAIT: begin
				if ($urandom_range(9) < 3)
					conv_word = pick_word();
				d = ($urandom_range(2) != 0);
			end
			RD_BIT_HIGH: d = conv_word[WORD_BITS - 1 - bit_cnt];
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [lcsr_pkg::CFG_IDX_W-1:0] idx,
			input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			lcsr_pkg::CFG_GAIN:  reg_gain  = val[1:0];
			lcsr_pkg::CFG_AVG:   reg_avg   = val[4:0];
			lcsr_pkg::CFG_SCALE: reg_scale = val;
			default: ;
		endcase
	endtask

	// Stops offering ticks until every queued reading has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (readings_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_field(input string what, input longint want, input longint seen);
		if (want != seen) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
		end
	endtask

	// Output side: checks each transaction and applies random or long stalls.
	initial begin : result_sink
		int       hold_left;
		reading_t got;
		reading_t want;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.sck   = m_tdata[0];
				got.busy  = m_tdata[1];
				got.done  = m_tdata[2];
				got.value = m_tdata[27:3];
				got.kind  = m_tuser[0];
				if (readings_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected output transaction, expected none, actual %h",
						$time, m_tdata);
				end else begin
					want = readings_q.pop_front();
					check_field("sck_level", want.sck, got.sck);
					check_field("busy_res", want.busy, got.busy);
					check_field("result_valid", want.done, got.done);
					check_field("result_kind", want.kind, got.kind);
					check_field("result_value", $signed(want.value), $signed(got.value));
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_TICKS;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		logic [1:0]  f;
		logic        d;
		logic [23:0] g_val;
		logic [23:0] a_val;
		logic [23:0] s_val;
		int          quota;
		int          min_runs;
		int          sent;
		int          runs_at_start;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FUNC_TICK;
		cfg_valid <= 1'b0;
		cfg_index <= lcsr_pkg::CFG_GAIN;
		cfg_data  <= '0;
		mismatches    = 0;
		finished_runs = 0;
		hold_request  = 1'b0;
		conv_word     = '0;
		rd_state  = RD_IDLE;
		bit_cnt   = 0;
		shift_reg = '0;
		acc_sum   = '0;
		acc_cnt   = 0;
		zero_ofs  = '0;
		tare_run  = 1'b0;
		sck_lvl   = 1'b0;
		reg_gain  = 2'd1;
		reg_avg   = 5'd5;
		reg_scale = 24'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Phase 0 runs at reset settings. The later phases rewrite all three
		// registers between runs, often while a sequence is half done, and
		// cover the zero and saturating cases of each register.
		for (int p = 0; p < N_PHASES; p++) begin
			g_val = 24'd1;
			a_val = 24'd1;
			s_val = 24'd1;
			quota = 120;
			min_runs = 1;
			case (p)
				0: begin quota = 200; end
				1: begin g_val = 24'd3; quota = 150; min_runs = 2; end
				2: begin g_val = 24'd0; a_val = 24'd0; s_val = 24'd0; min_runs = 2; end
				3: begin g_val = 24'd2; a_val = 24'd2; s_val = 24'hFFFFFF; end
				4: begin a_val = 24'd31; s_val = 24'd1000; end
				5: begin
					g_val = 24'd3;
					a_val = 24'd2;
					s_val = 24'($urandom_range(24'hFFFFFF));
				end
				6: begin
					// Unused upper bits of the narrow registers carry noise.
					g_val = {22'($urandom), 2'($urandom_range(3))};
					a_val = {19'($urandom), 5'($urandom_range(1, 3))};
					s_val = ($urandom_range(1) == 0) ? 24'($urandom_range(1, 64))
						: 24'($urandom);
					quota = 150;
					min_runs = 2;
				end
				default: ;
			endcase
			if (p != 0) begin
				drain();
				write_reg(lcsr_pkg::CFG_GAIN, g_val);
				write_reg(lcsr_pkg::CFG_AVG, a_val);
				write_reg(lcsr_pkg::CFG_SCALE, s_val);
				cfg_valid <= 1'b0;
			end
			// Sender dense and receiver slow first, then the reverse, then
			// full rate on both sides.
			send_idle_pct = (p < 2) ? 6 : (p < 4) ? 61 : 0;
			recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 6 : 0;
			// Long output stall while ticks keep coming, to fill the block.
			if (p == 1)
				hold_request = 1'b1;
			sent = 0;
			runs_at_start = finished_runs;
			if (p == 0) begin
				foreach (OPENING_TICKS[i]) begin
					send_tick(OPENING_TICKS[i].func, OPENING_TICKS[i].dout,
						OPENING_TICKS[i].known, OPENING_TICKS[i].want);
					sent++;
				end
			end
			while (sent < quota || finished_runs - runs_at_start < min_runs) begin
				next_tick(f, d);
				send_tick(f, d, 1'b0, QUIET);
				sent++;
			end
		end

		drain();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
